>>> rtl/popularity_palette_quantizer_defines.svh
// assertion macros for the popularity palette quantizer
`ifndef POPULARITY_PALETTE_QUANTIZER_DEFINES_SVH
`define POPULARITY_PALETTE_QUANTIZER_DEFINES_SVH
// implication checked every clock outside reset
`define PPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define PPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/ppq_pkg.sv
// shared constants and types for the popularity palette quantizer
`default_nettype none
package ppq_pkg;
  localparam int unsigned MaxColors   = 4096;
  localparam int unsigned PaletteSize = 256;
  localparam int unsigned HitBits     = 24;
  localparam int unsigned AddrW       = $clog2(MaxColors);
  localparam int unsigned FillW       = AddrW + 1;
  localparam int unsigned PalW        = $clog2(PaletteSize);
  localparam int unsigned KeyW        = 24;
  localparam logic [HitBits-1:0] HitMax = {HitBits{1'b1}};

  typedef enum logic [2:0] {
    CmdCount = 3'd0,
    CmdBuild = 3'd1,
    CmdMap   = 3'd2,
    CmdRead  = 3'd3,
    CmdClear = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFew      = 2'd1,
    StFull     = 2'd2,
    StNotBuilt = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] entry_select;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  palette_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [12:0] distinct_colors;
  } out_item_t;
endpackage
`default_nettype wire

>>> rtl/ppq_stream_if.sv
// valid/ready stream interfaces for input and result items
`default_nettype none
interface ppq_in_if;
  logic                valid;
  logic                ready;
  ppq_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppq_out_if;
  logic                valid;
  logic                ready;
  ppq_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ppq_ram.sv
// generic single-port-write, single-read ram with registered read
`default_nettype none
module ppq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/ppq_dist.sv
// squared rgb distance of a palette color to a pixel (squares registered, sum combinational)
`default_nettype none
module ppq_dist (
  input  wire logic        clk_i,
  input  wire logic [23:0] key_i,
  input  wire logic [7:0]  red_i,
  input  wire logic [7:0]  green_i,
  input  wire logic [7:0]  blue_i,
  output logic      [17:0] dist_o
);
  logic [7:0]  dr, dg, db;
  logic [15:0] sr_q, sg_q, sb_q;
  always_comb begin
    dr = (key_i[23:16] > red_i) ? key_i[23:16] - red_i : red_i - key_i[23:16];
    dg = (key_i[15:8] > green_i) ? key_i[15:8] - green_i : green_i - key_i[15:8];
    db = (key_i[7:0] > blue_i) ? key_i[7:0] - blue_i : blue_i - key_i[7:0];
  end
  always_ff @(posedge clk_i) begin
    sr_q <= dr * dr;
    sg_q <= dg * dg;
    sb_q <= db * db;
  end
  assign dist_o = {2'b00, sr_q} + {2'b00, sg_q} + {2'b00, sb_q};
endmodule
`default_nettype wire

>>> rtl/popularity_palette_quantizer.sv
// top level: popularity color quantizer built around the color and palette memories
//
//  channel   dir  handshake     payload
//  in_item   in   valid/ready   command, red, green, blue, entry_select
//  out_item  out  valid/ready   status, palette_index, out_red/green/blue, distinct_colors
//
// one item at a time; ready is high only when the sequencer is idle and no result waits
// count: linear search of the color memory, one read a cycle
// build: selection sort over fill entries, then a 256-entry copy into the palette
//   memory; map: nearest of all 256 palette entries; read: one entry by entry_select
// reset clears fill count, palette flag and the control; memories need no clearing
// a stalled result holds in the output register until taken
`default_nettype none
`include "popularity_palette_quantizer_defines.svh"
module popularity_palette_quantizer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppq_in_if.sink    in_item,
  ppq_out_if.source out_item
);
  localparam int unsigned AW = ppq_pkg::AddrW;
  localparam int unsigned FW = ppq_pkg::FillW;
  localparam int unsigned PW = ppq_pkg::PalW;
  localparam int unsigned HW = ppq_pkg::HitBits;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CSCAN = 13'b0000000000010, // count: compare key read last cycle
    S_CUPD  = 13'b0000000000100, // count: bump hit of found entry or append a new one
    S_SSCAN = 13'b0000000001000, // sort: scan for largest hit
    S_SRDI  = 13'b0000000010000, // sort: read entry i
    S_SWAP1 = 13'b0000000100000, // sort: write i into best slot
    S_SWAP2 = 13'b0000001000000, // sort: write best into i
    S_CPY   = 13'b0000010000000, // copy top keys into palette
    S_MAP   = 13'b0000100000000, // map: stream distances
    S_MEND  = 13'b0001000000000, // map: read chosen color
    S_RD    = 13'b0010000000000, // read: wait for palette data
    S_DONE  = 13'b0100000000000, // present color from palette ram
    S_OUT   = 13'b1000000000000  // result waits in output register
  } state_e;

  state_e state_q, state_d;

  ppq_pkg::in_item_t  cmd_q;
  ppq_pkg::out_item_t res_q, res_d;
  logic               res_valid_q, res_valid_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic               ready_flag_q, ready_flag_d;

  // color table memories (key and hit at same address)
  logic          tab_we;
  logic [AW-1:0] tab_waddr, tab_raddr;
  logic [23:0]   key_wdata, key_rdata;
  logic [HW-1:0] hit_wdata, hit_rdata;
  // palette memory
  logic          pal_we;
  logic [PW-1:0] pal_waddr, pal_raddr;
  logic [23:0]   pal_rdata;

  ppq_ram #(.Width(24), .Depth(ppq_pkg::MaxColors)) u_keys (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(key_wdata),
    .raddr_i(tab_raddr), .rdata_o(key_rdata));
  ppq_ram #(.Width(HW), .Depth(ppq_pkg::MaxColors)) u_hits (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(hit_wdata),
    .raddr_i(tab_raddr), .rdata_o(hit_rdata));
  ppq_ram #(.Width(24), .Depth(ppq_pkg::PaletteSize)) u_pal (
    .clk_i, .we_i(pal_we), .waddr_i(pal_waddr), .wdata_i(key_rdata),
    .raddr_i(pal_raddr), .rdata_o(pal_rdata));

  logic [17:0] pix_dist;
  ppq_dist u_dist (
    .clk_i, .key_i(pal_rdata), .red_i(cmd_q.red), .green_i(cmd_q.green),
    .blue_i(cmd_q.blue), .dist_o(pix_dist));

  // walking counters
  logic [FW-1:0] ptr_q, ptr_d;      // address issued this cycle
  logic [FW-1:0] cmp_q, cmp_d;      // address of data arriving
  logic [FW-1:0] pos_q, pos_d;      // sort position i
  logic [FW-1:0] best_q, best_d;    // best index
  logic [HW-1:0] bhit_q, bhit_d;
  logic [23:0]   bkey_q, bkey_d;
  logic [23:0]   ikey_q, ikey_d;
  logic [HW-1:0] ihit_q, ihit_d;
  logic [PW:0]   mcnt_q, mcnt_d;    // map entry counter
  logic [17:0]   mbest_q, mbest_d;
  logic [PW-1:0] midx_q, midx_d;

  logic [23:0] cur_key;
  assign cur_key = {cmd_q.red, cmd_q.green, cmd_q.blue};

  assign in_item.ready  = (state_q == S_IDLE) && !res_valid_q;
  assign out_item.valid = res_valid_q;
  assign out_item.data  = res_q;

  always_comb begin
    state_d = state_q; res_d = res_q; res_valid_d = res_valid_q;
    fill_d = fill_q; ready_flag_d = ready_flag_q;
    ptr_d = ptr_q; cmp_d = cmp_q; pos_d = pos_q; best_d = best_q;
    bhit_d = bhit_q; bkey_d = bkey_q; ikey_d = ikey_q; ihit_d = ihit_q;
    mcnt_d = mcnt_q; mbest_d = mbest_q; midx_d = midx_q;
    tab_we = 1'b0; tab_waddr = cmp_q[AW-1:0]; tab_raddr = ptr_q[AW-1:0];
    key_wdata = cur_key; hit_wdata = '0;
    pal_we = 1'b0; pal_waddr = cmp_q[PW-1:0]; pal_raddr = ptr_q[PW-1:0];
    if (res_valid_q && out_item.ready) res_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_item.valid && in_item.ready) begin
          res_d = '0;
          ptr_d = '0; cmp_d = '0;
          case (in_item.data.command)
            ppq_pkg::CmdCount: begin
              if (fill_q == '0) begin
                state_d = S_CUPD;  // append directly
                best_d = '0;
                bhit_d = '0;
                cmp_d = fill_q;
              end else begin
                tab_raddr = '0; ptr_d = FW'(1); state_d = S_CSCAN;
              end
            end
            ppq_pkg::CmdBuild: begin
              if (fill_q < FW'(ppq_pkg::PaletteSize)) begin
                res_d.status = ppq_pkg::StFew; ready_flag_d = 1'b0;
                state_d = S_OUT;
              end else begin
                pos_d = '0; tab_raddr = '0; ptr_d = FW'(1); cmp_d = '0;
                state_d = S_SSCAN; bhit_d = '0; best_d = '0;
              end
            end
            ppq_pkg::CmdMap: begin
              if (!ready_flag_q) begin
                res_d.status = ppq_pkg::StNotBuilt; state_d = S_OUT;
              end else begin
                pal_raddr = '0; ptr_d = FW'(1); mcnt_d = '0; mbest_d = '1;
                midx_d = '0; state_d = S_MAP;
              end
            end
            ppq_pkg::CmdRead: begin
              if (!ready_flag_q) begin
                res_d.status = ppq_pkg::StNotBuilt; state_d = S_OUT;
              end else begin
                pal_raddr = in_item.data.entry_select[PW-1:0];
                res_d.palette_index = 8'(in_item.data.entry_select[PW-1:0]);
                state_d = S_RD;
              end
            end
            ppq_pkg::CmdClear: begin
              fill_d = '0; state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_CSCAN: begin
        // data at cmp_q arrives now
        if (key_rdata == cur_key) begin
          bhit_d = hit_rdata; best_d = cmp_q; state_d = S_CUPD;
        end else if (cmp_q + FW'(1) == fill_q) begin
          if (fill_q == FW'(ppq_pkg::MaxColors)) begin
            res_d.status = ppq_pkg::StFull; state_d = S_OUT;
          end else begin
            best_d = fill_q; bhit_d = '0; state_d = S_CUPD;
          end
        end else begin
          cmp_d = cmp_q + FW'(1); ptr_d = ptr_q + FW'(1);
        end
      end
      S_CUPD: begin
        tab_we = 1'b1; tab_waddr = best_q[AW-1:0];
        if (best_q == fill_q) begin
          hit_wdata = HW'(1); fill_d = fill_q + FW'(1);
        end else begin
          hit_wdata = (bhit_q == ppq_pkg::HitMax) ? bhit_q : bhit_q + HW'(1);
        end
        state_d = S_OUT;
      end
      S_SSCAN: begin
        // strict greater keeps the first largest
        if (cmp_q == pos_q || hit_rdata > bhit_q) begin
          bhit_d = hit_rdata; bkey_d = key_rdata; best_d = cmp_q;
        end
        if (cmp_q + FW'(1) == fill_q) begin
          tab_raddr = pos_q[AW-1:0]; state_d = S_SRDI;
        end else begin
          cmp_d = cmp_q + FW'(1); ptr_d = ptr_q + FW'(1);
        end
      end
      S_SRDI: begin
        ikey_d = key_rdata; ihit_d = hit_rdata;
        state_d = S_SWAP1;
      end
      S_SWAP1: begin
        tab_we = 1'b1; tab_waddr = best_q[AW-1:0];
        key_wdata = ikey_q; hit_wdata = ihit_q; state_d = S_SWAP2;
      end
      S_SWAP2: begin
        tab_we = 1'b1; tab_waddr = pos_q[AW-1:0];
        key_wdata = bkey_q; hit_wdata = bhit_q;
        if (pos_q + FW'(2) >= fill_q) begin
          tab_raddr = '0; ptr_d = FW'(1); cmp_d = '0; state_d = S_CPY;
        end else begin
          pos_d = pos_q + FW'(1); tab_raddr = pos_q[AW-1:0] + AW'(1);
          ptr_d = pos_q + FW'(2); cmp_d = pos_q + FW'(1); state_d = S_SSCAN;
        end
      end
      S_CPY: begin
        pal_we = 1'b1; pal_waddr = cmp_q[PW-1:0];
        if (cmp_q == FW'(ppq_pkg::PaletteSize - 1)) begin
          ready_flag_d = 1'b1; state_d = S_OUT;
        end else begin
          cmp_d = cmp_q + FW'(1); ptr_d = ptr_q + FW'(1);
        end
      end
      S_MAP: begin
        // pal data lags ptr by 1, distance of entry n shows at count n + 1
        ptr_d = ptr_q + FW'(1);
        mcnt_d = mcnt_q + (PW+1)'(1);
        if (mcnt_q >= (PW+1)'(1)) begin
          if (pix_dist <= mbest_q) begin
            mbest_d = pix_dist; midx_d = PW'(mcnt_q - (PW+1)'(1));
          end
        end
        if (mcnt_q == (PW+1)'(ppq_pkg::PaletteSize)) state_d = S_MEND;
      end
      S_MEND: begin
        pal_raddr = midx_q; res_d.palette_index = 8'(midx_q); state_d = S_RD;
      end
      S_RD: begin
        // keep the chosen entry on the read port
        pal_raddr = res_q.palette_index[PW-1:0]; state_d = S_DONE;
      end
      S_DONE: begin
        res_d.out_red = pal_rdata[23:16]; res_d.out_green = pal_rdata[15:8];
        res_d.out_blue = pal_rdata[7:0]; state_d = S_OUT;
      end
      S_OUT: begin
        res_d.distinct_colors = 13'(fill_q);
        res_valid_d = 1'b1; state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; res_valid_q <= 1'b0; fill_q <= '0; ready_flag_q <= 1'b0;
    end else begin
      state_q <= state_d; res_valid_q <= res_valid_d;
      fill_q <= fill_d; ready_flag_q <= ready_flag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_item.valid && in_item.ready) cmd_q <= in_item.data;
    res_q <= res_d;
    ptr_q <= ptr_d; cmp_q <= cmp_d; pos_q <= pos_d; best_q <= best_d;
    bhit_q <= bhit_d; bkey_q <= bkey_d; ikey_q <= ikey_d; ihit_q <= ihit_d;
    mcnt_q <= mcnt_d; mbest_q <= mbest_d; midx_q <= midx_d;
  end

  `PPQ_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= FW'(ppq_pkg::MaxColors),
    "fill count beyond table depth")
  `PPQ_ASSERT_IMP(a_no_accept_busy, state_q != S_IDLE, !in_item.ready,
    "item accepted while busy")
  `PPQ_ASSERT_NEXT(a_out_sets_valid, state_q == S_OUT, res_valid_q,
    "result not raised after finishing")
  `PPQ_ASSERT_IMP(a_sort_bound, state_q == S_SSCAN, cmp_q < fill_q,
    "sort scan beyond table fill")
endmodule
`default_nettype wire
